// ===== rtl/core/sspb_pkg.sv =====
// Shared types, constants and the digit segment table for the panel frame buffer.
// Depends on nothing; the controller, datapath and top level import it.
`default_nettype none

package sspb_pkg;

   localparam int unsigned FRAME_LEN      = 16;
   localparam int unsigned INDEX_W        = $clog2(FRAME_LEN);
   localparam int unsigned MODE_KEY_LIMIT = 12;

   localparam logic [15:0] BLANK_VALUE = 16'hFFFF;
   localparam logic [7:0]  SEG_POINT   = 8'h80;

   // Division reciprocals: 60 and 100 exact over the full 16-bit range, 10 below 1024.
   localparam int unsigned QUOT_W    = 11;
   localparam logic [16:0] RECIP_60  = 17'd34953;
   localparam int unsigned SHIFT_60  = 21;
   localparam logic [16:0] RECIP_100 = 17'd83887;
   localparam int unsigned SHIFT_100 = 23;
   localparam logic [7:0]  RECIP_10  = 8'd205;
   localparam int unsigned SHIFT_10  = 11;

   localparam int unsigned TEMP_BYTE  = 0;
   localparam int unsigned STEAM_BYTE = 3;
   localparam int unsigned TIME_BYTE  = 6;
   localparam int unsigned LED_BYTE   = 10;
   localparam int unsigned LED_BYTES  = 6;
   localparam logic [7:0]  LED_LAST   = 8'd48;

   typedef enum logic [3:0] {
      OP_TIME     = 4'd0,
      OP_TEMP     = 4'd1,
      OP_STEAM    = 4'd2,
      OP_LED      = 4'd3,
      OP_PROG_LED = 4'd4,
      OP_KEY_OFF  = 4'd5,
      OP_ALL_OFF  = 4'd6,
      OP_FAN_F    = 4'd7,
      OP_MODE     = 4'd8
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_REMAINDER,
      ST_DIGITS,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic divide;
      logic remainder;
      logic digits;
      logic update;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_loaded;
   } status_type;

   typedef logic [FRAME_LEN-1:0][7:0] frame_type;

   function automatic logic [7:0] digit_of(input logic [QUOT_W-1:0] idx);
      logic [7:0] seg;
      case (idx)
         11'd0:   seg = 8'h3f;
         11'd1:   seg = 8'h06;
         11'd2:   seg = 8'h5b;
         11'd3:   seg = 8'h4f;
         11'd4:   seg = 8'h66;
         11'd5:   seg = 8'h6d;
         11'd6:   seg = 8'h7d;
         11'd7:   seg = 8'h07;
         11'd8:   seg = 8'h7f;
         11'd9:   seg = 8'h6f;
         11'd11:  seg = 8'h71;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sspb_req_if.sv =====
// Command channel of the panel frame buffer: valid, ready and the command fields.
// Stands alone; used by the top level and its environment.
`default_nettype none

interface sspb_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  opcode;
   logic [15:0] value;
   logic [7:0]  item_number;
   logic        on_off;
   logic [2:0]  f_index;
   logic [2:0]  fan_index;

   modport source (output valid, opcode, value, item_number, on_off, f_index, fan_index,
                   input ready);
   modport sink (input valid, opcode, value, item_number, on_off, f_index, fan_index,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sspb_rsp_if.sv =====
// Frame byte channel of the panel frame buffer: valid, ready and one frame byte.
// Stands alone; used by the top level and its environment.
`default_nettype none

interface sspb_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] byte_index;
   logic [7:0] byte_value;
   logic       last;

   modport source (output valid, byte_index, byte_value, last, input ready);
   modport sink (input valid, byte_index, byte_value, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sspb_controller.sv =====
// Sequencing state machine of the panel frame buffer.
// Depends on sspb_pkg for the state, command and status types.
`default_nettype none

module sspb_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sspb_pkg::status_type  status,
   output sspb_pkg::cmd_type     cmd
);
   import sspb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) state_in = ST_DIVIDE;
         end
         ST_DIVIDE:    state_in = ST_REMAINDER;
         ST_REMAINDER: state_in = ST_DIGITS;
         ST_DIGITS:    state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.last_loaded) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready    = 1'b1;
            cmd.capture = in_valid;
         end
         ST_DIVIDE:    cmd.divide    = 1'b1;
         ST_REMAINDER: cmd.remainder = 1'b1;
         ST_DIGITS:    cmd.digits    = 1'b1;
         ST_UPDATE:    cmd.update    = 1'b1;
         ST_EMIT:      cmd.load_out  = status.out_free;
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> state_ff == ST_DIVIDE)
      else $error("accepted command did not start the arithmetic sequence");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && status.last_loaded) |=> in_ready)
      else $error("controller did not return to idle after the last frame byte");

   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      in_ready |-> !cmd.load_out && !cmd.update)
      else $error("frame activity while the command channel is open");

endmodule

`default_nettype wire

// ===== rtl/core/sspb_datapath.sv =====
// Datapath of the panel frame buffer: command registers, reciprocal dividers,
// frame register file and the output register. Depends on sspb_pkg.
`default_nettype none

module sspb_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  sspb_pkg::cmd_type     cmd,
   output sspb_pkg::status_type  status,
   input  logic [3:0]            opcode,
   input  logic [15:0]           value,
   input  logic [7:0]            item_number,
   input  logic                  on_off,
   input  logic [2:0]            f_index,
   input  logic [2:0]            fan_index,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [3:0]            byte_index,
   output logic [7:0]            byte_value,
   output logic                  last
);
   import sspb_pkg::*;

   opcode_type          opcode_ff;
   logic [15:0]         value_ff;
   logic [7:0]          item_ff;
   logic                on_ff;
   logic [2:0]          f_ff;
   logic [2:0]          fan_ff;

   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [6:0]          rem_ff, rem_in;
   logic [6:0]          adiv_ff, adiv_in;
   logic [3:0]          amod_ff, amod_in;
   logic [3:0]          bdiv_ff, bdiv_in;
   logic [3:0]          bmod_ff, bmod_in;

   frame_type           frame_ff, frame_in;
   logic [INDEX_W-1:0]  cnt_ff, cnt_in;
   logic                valid_ff, valid_in;
   logic [INDEX_W-1:0]  index_ff;
   logic [7:0]          data_ff;
   logic                last_ff;

   logic                is_time;
   logic [32:0]         quot_prod;
   logic [15:0]         rem_full;
   logic [QUOT_W-1:0]   a_src;
   logic [18:0]         a_prod;
   logic [14:0]         b_prod;
   logic [QUOT_W-1:0]   a_times10;
   logic [6:0]          b_times10;
   logic [6:0]          min_tens;
   logic [7:0]          led_n;
   logic [7:0]          mode_k;
   logic                cnt_last;

   assign is_time = (opcode_ff == OP_TIME);

   // Quotient by 60 for time, by 100 for the other fields.
   always_comb begin
      if (is_time) begin
         quot_prod = 33'(value_ff) * 33'(RECIP_60);
         quot_in   = QUOT_W'(quot_prod >> SHIFT_60);
      end else begin
         quot_prod = 33'(value_ff) * 33'(RECIP_100);
         quot_in   = QUOT_W'(quot_prod >> SHIFT_100);
      end
   end

   assign rem_full = is_time ? (value_ff - 16'(quot_ff) * 16'd60)
                             : (value_ff - 16'(quot_ff) * 16'd100);
   assign rem_in   = rem_full[6:0];

   // Minutes are taken modulo 256 before the decimal split.
   assign a_src     = is_time ? QUOT_W'(quot_ff[7:0]) : quot_ff;
   assign a_prod    = 19'(a_src) * 19'(RECIP_10);
   assign adiv_in   = 7'(a_prod >> SHIFT_10);
   assign a_times10 = QUOT_W'(adiv_in) * QUOT_W'(10);
   assign amod_in   = 4'(a_src - a_times10);
   assign b_prod    = 15'(rem_ff) * 15'(RECIP_10);
   assign bdiv_in   = 4'(b_prod >> SHIFT_10);
   assign b_times10 = 7'(bdiv_in) * 7'd10;
   assign bmod_in   = 4'(rem_ff - b_times10);

   always_comb begin
      if (adiv_ff >= 7'd20) begin
         min_tens = adiv_ff - 7'd20;
      end else if (adiv_ff >= 7'd10) begin
         min_tens = adiv_ff - 7'd10;
      end else begin
         min_tens = adiv_ff;
      end
   end

   assign led_n  = item_ff - 8'd1;
   assign mode_k = item_ff - 8'd1;

   always_comb begin
      frame_in = frame_ff;
      if (cmd.update) begin
         case (opcode_ff)
            OP_TIME: begin
               if (value_ff == BLANK_VALUE) begin
                  for (int i = 0; i < 4; i++) frame_in[TIME_BYTE + i] = '0;
               end else begin
                  frame_in[TIME_BYTE]     = digit_of(QUOT_W'(min_tens));
                  frame_in[TIME_BYTE + 1] = digit_of(QUOT_W'(amod_ff)) | SEG_POINT;
                  frame_in[TIME_BYTE + 2] = digit_of(QUOT_W'(bdiv_ff));
                  frame_in[TIME_BYTE + 3] = digit_of(QUOT_W'(bmod_ff));
               end
            end
            OP_TEMP: begin
               if (value_ff == BLANK_VALUE) begin
                  for (int i = 0; i < 3; i++) frame_in[TEMP_BYTE + i] = '0;
               end else begin
                  frame_in[TEMP_BYTE]     = digit_of(quot_ff);
                  frame_in[TEMP_BYTE + 1] = digit_of(QUOT_W'(bdiv_ff));
                  frame_in[TEMP_BYTE + 2] = digit_of(QUOT_W'(bmod_ff));
               end
            end
            OP_STEAM: begin
               if (value_ff == BLANK_VALUE) begin
                  for (int i = 0; i < 3; i++) frame_in[STEAM_BYTE + i] = '0;
               end else begin
                  frame_in[STEAM_BYTE]     = digit_of(QUOT_W'(amod_ff));
                  frame_in[STEAM_BYTE + 1] = digit_of(QUOT_W'(bdiv_ff));
                  frame_in[STEAM_BYTE + 2] = digit_of(QUOT_W'(bmod_ff));
               end
            end
            OP_LED: begin
               if (item_ff != 8'd0 && item_ff <= LED_LAST) begin
                  for (int j = 0; j < LED_BYTES; j++) begin
                     if (led_n[5:3] == 3'(j)) begin
                        frame_in[LED_BYTE + j][led_n[2:0]] = on_ff;
                     end
                  end
               end
            end
            OP_PROG_LED: begin
               frame_in[LED_BYTE]          = on_ff ? 8'hFF : 8'h00;
               frame_in[LED_BYTE + 1][3:0] = on_ff ? 4'hF : 4'h0;
            end
            OP_KEY_OFF: begin
               frame_in[LED_BYTE]          = '0;
               frame_in[LED_BYTE + 1]      = '0;
               frame_in[LED_BYTE + 2]      = '0;
               frame_in[LED_BYTE + 3][2:0] = '0;
            end
            OP_ALL_OFF: begin
               frame_in = '0;
            end
            OP_FAN_F: begin
               frame_in[LED_BYTE + 3][7:4] = (fan_ff[2] == 1'b0) ? (4'd1 << fan_ff[1:0]) : 4'd0;
               frame_in[LED_BYTE + 4][4:0] = '0;
               frame_in[LED_BYTE + 4]      = frame_in[LED_BYTE + 4] | (8'd1 << f_ff);
            end
            OP_MODE: begin
               if (item_ff != 8'd0 && item_ff <= 8'(MODE_KEY_LIMIT)) begin
                  if (mode_k[3] == 1'b0) begin
                     frame_in[LED_BYTE]     = 8'd1 << mode_k[2:0];
                     frame_in[LED_BYTE + 1] = '0;
                  end else begin
                     frame_in[LED_BYTE + 1] = 8'd1 << mode_k[2:0];
                     frame_in[LED_BYTE]     = '0;
                  end
               end
            end
            default: begin
               frame_in = frame_ff;
            end
         endcase
      end
   end

   assign cnt_last = (cnt_ff == INDEX_W'(FRAME_LEN - 1));
   assign cnt_in   = cmd.load_out ? cnt_ff + INDEX_W'(1) : cnt_ff;
   assign valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   assign status.out_free    = !valid_ff || rsp_ready;
   assign status.last_loaded = cmd.load_out && cnt_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         frame_ff <= frame_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff <= opcode_type'(opcode);
         value_ff  <= value;
         item_ff   <= item_number;
         on_ff     <= on_off;
         f_ff      <= f_index;
         fan_ff    <= fan_index;
      end
      if (cmd.divide) begin
         quot_ff <= quot_in;
      end
      if (cmd.remainder) begin
         rem_ff <= rem_in;
      end
      if (cmd.digits) begin
         adiv_ff <= adiv_in;
         amod_ff <= amod_in;
         bdiv_ff <= bdiv_in;
         bmod_ff <= bmod_in;
      end
      if (cmd.load_out) begin
         index_ff <= cnt_ff;
         data_ff  <= frame_ff[cnt_ff];
         last_ff  <= cnt_last;
      end
   end

   assign rsp_valid  = valid_ff;
   assign byte_index = index_ff;
   assign byte_value = data_ff;
   assign last       = last_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> valid_ff && index_ff == $past(cnt_ff))
      else $error("loaded frame byte is not presented");

   a_last_tag: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (last_ff == (index_ff == INDEX_W'(FRAME_LEN - 1))))
      else $error("last flag does not match the frame position");

   a_frame_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !cmd.update && status.out_free)
      else $error("frame changed or output overwritten during emission");

endmodule

`default_nettype wire

// ===== rtl/core/seven_segment_panel_buffer.sv =====
// Top level of the seven-segment panel frame buffer.
// Depends on sspb_pkg, sspb_req_if, sspb_rsp_if, sspb_controller and sspb_datapath.
`default_nettype none

// Each accepted command updates a sixteen-byte display frame and then sends all
// sixteen bytes, index 0 first, with last set on byte 15. After a transfer on
// the command channel the block works in turn through a reciprocal multiply for
// the quotient by 60 or 100, the remainder, the decimal digit split and the frame
// write, and then loads one frame byte per cycle into a single output register
// while the byte channel is ready. The command channel opens again as soon as
// byte 15 sits in the output register, so the next command overlaps the last
// byte transfer. The frame is all zeros after reset.
module seven_segment_panel_buffer (
   input  logic        clock,
   input  logic        reset,
   sspb_req_if.sink    req_chan,
   sspb_rsp_if.source  rsp_chan
);
   import sspb_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ctrl_ready;

   sspb_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (ctrl_ready),
      .status   (status),
      .cmd      (cmd)
   );

   sspb_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .opcode      (req_chan.opcode),
      .value       (req_chan.value),
      .item_number (req_chan.item_number),
      .on_off      (req_chan.on_off),
      .f_index     (req_chan.f_index),
      .fan_index   (req_chan.fan_index),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .byte_index  (rsp_chan.byte_index),
      .byte_value  (rsp_chan.byte_value),
      .last        (rsp_chan.last)
   );

   assign req_chan.ready = ctrl_ready;

endmodule

`default_nettype wire
